// ===== rtl/core/fpra_pkg.sv =====
// Package for the free page range allocator: widths, codes, payload types and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none
package fpra_pkg;

  localparam int unsigned MaxRanges  = 64;
  localparam int unsigned FrameW     = 52;
  localparam int unsigned IdxW       = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam int unsigned CntW       = $clog2(MaxRanges + 1);
  localparam logic [FrameW-1:0] PageStep = FrameW'(64'h1000);

  typedef logic [FrameW-1:0] frame_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [IdxW-1:0]   idx_t;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] cmd;
    frame_t     range_start;
    frame_t     range_end;
  } req_t;

  typedef struct packed {
    frame_t     page_frame;
    logic [1:0] status;
  } rsp_t;

  // One table entry: first frame and one-past-last frame.
  typedef struct packed {
    frame_t first;
    frame_t last;
  } entry_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_READ_I,
    DP_LATCH,
    DP_REQ_WRITE,
    DP_REQ_DROP,
    DP_ADD_SETSTART,
    DP_ADD_SETEND,
    DP_INS_AT_I,
    DP_INC_I,
    DP_RSV_TRUNC,
    DP_RSV_SPLIT,
    DP_RSV_CUTEND,
    DP_RSV_DROP,
    DP_RSV_SETSTART,
    DP_RSV_SKIP,
    DP_UP_RD,
    DP_UP_WR,
    DP_INS_WR,
    DP_DN_RD,
    DP_DN_WR,
    DP_DROP_DONE,
    DP_RESP
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_WAIT,
    S_EVAL,
    S_INS_CHK,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_DN_CHK,
    S_DN_RD,
    S_DN_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic i_ge_cnt;
    logic k_gt_p;
    logic k1_lt_cnt;
    logic req_hit;
    logic cs_eq_e;
    logic ce_eq_s;
    logic cs_gt_e;
    logic cs_lt_s;
    logic cs_eq_s;
    logic ce_lt_e;
    logic ce_gt_s;
    logic ce_gt_e;
    logic ce_eq_e;
    logic cs_ge_e;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/fpra_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on fpra_pkg for the payload types.
`default_nettype none
interface fpra_req_if;
  logic             valid;
  logic             ready;
  fpra_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fpra_rsp_if;
  logic             valid;
  logic             ready;
  fpra_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/free_page_range_allocator.sv =====
// Free page range allocator: one command beat in, one response beat out.
// A request may move entries down on a drop; add and reserve walk the table entry by entry and
// may move entries for an insert or a drop. A reserve that drops a run of entries shifts the
// table once per drop. One command is in work at a time.
// Reset: asynchronous active low; it empties the table (count zero) with no clearing pass.
`default_nettype none
module free_page_range_allocator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fpra_req_if.sink    req_i,
  fpra_rsp_if.source  rsp_o
);
  import fpra_pkg::*;

  // Commands from the controller steer the datapath one step per cycle, holding the response step
  // while the result is unaccepted; the datapath answers with compare results and table occupancy.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  fpra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .in_cmd_i   (req_i.data.cmd),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // The response register lets a finished beat wait while the next command
  // is taken.
  fpra_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i.data),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (rsp_o.data)
  );

  // In the cycle after a command beat is taken the block is not ready.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("accepted a second command beat back to back");

  // A full status is only reported while the table really holds its maximum.
  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(rsp_o.valid) && rsp_o.data.status == ST_FULL) |-> dp_stat.cnt_full)
    else $error("full status with free table slots");

  // An empty status is only reported when the table holds no range.
  a_empty_means_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(rsp_o.valid) && rsp_o.data.status == ST_EMPTY) |-> dp_stat.cnt_zero)
    else $error("empty status with ranges in the table");
endmodule
`default_nettype wire

// ===== rtl/core/fpra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fpra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/fpra_dp.sv =====
// Datapath: range table RAM, walk and shift indexes, entry compares, result register.
// Depends on fpra_pkg and fpra_ram.
`default_nettype none
module fpra_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fpra_pkg::req_t    req_i,
  input  wire fpra_pkg::dp_cmd_t cmd_i,
  output fpra_pkg::dp_stat_t     stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output fpra_pkg::rsp_t         out_data_o
);
  import fpra_pkg::*;

  cnt_t   count_q, i_q, k_q, p_q;
  frame_t s_q, e_q, frame_q;
  entry_t cur_q, ins_q, rdata, wdata;
  logic   we, re;
  idx_t   waddr, raddr;
  logic   out_valid_q;
  rsp_t   out_q;
  cnt_t   k_dec, k_inc, i_inc;
  frame_t next_first;

  assign k_dec      = k_q - cnt_t'(1);
  assign k_inc      = k_q + cnt_t'(1);
  assign i_inc      = i_q + cnt_t'(1);
  assign next_first = cur_q.first + PageStep;

  fpra_ram #(.Width($bits(entry_t)), .Depth(MaxRanges)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = i_q[IdxW-1:0];
    raddr = i_q[IdxW-1:0];
    wdata = '{first: cur_q.first, last: s_q};
    unique case (cmd_i.op)
      DP_READ_I:       re = 1'b1;
      DP_UP_RD: begin
        re    = 1'b1;
        raddr = k_dec[IdxW-1:0];
      end
      DP_DN_RD: begin
        re    = 1'b1;
        raddr = k_inc[IdxW-1:0];
      end
      DP_REQ_WRITE: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{first: next_first, last: cur_q.last};
      end
      DP_ADD_SETSTART: begin
        we    = 1'b1;
        wdata = '{first: s_q, last: cur_q.last};
      end
      DP_ADD_SETEND: begin
        we    = 1'b1;
        wdata = '{first: cur_q.first, last: e_q};
      end
      DP_RSV_TRUNC, DP_RSV_SPLIT, DP_RSV_CUTEND: we = 1'b1;
      DP_RSV_SETSTART: begin
        we    = 1'b1;
        wdata = '{first: e_q, last: cur_q.last};
      end
      DP_UP_WR, DP_DN_WR: begin
        we    = 1'b1;
        waddr = k_q[IdxW-1:0];
        wdata = rdata;
      end
      DP_INS_WR: begin
        we    = 1'b1;
        waddr = p_q[IdxW-1:0];
        wdata = ins_q;
      end
      default: ;
    endcase
  end

  // Control counters and the result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      i_q         <= '0;
      k_q         <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        DP_LOAD:      i_q <= '0;
        DP_REQ_DROP:  k_q <= '0;
        DP_INS_AT_I: begin
          p_q <= i_q;
          k_q <= count_q;
        end
        DP_INC_I, DP_RSV_TRUNC: i_q <= i_inc;
        DP_RSV_SPLIT: begin
          p_q <= i_inc;
          k_q <= count_q;
        end
        DP_RSV_DROP:  k_q <= i_q;
        DP_UP_WR:     k_q <= k_dec;
        DP_DN_WR:     k_q <= k_inc;
        DP_INS_WR:    count_q <= count_q + cnt_t'(1);
        DP_DROP_DONE: count_q <= count_q - cnt_t'(1);
        DP_RESP:      out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        s_q     <= req_i.range_start;
        e_q     <= req_i.range_end;
        frame_q <= '0;
      end
      DP_LATCH:                 cur_q   <= rdata;
      DP_REQ_WRITE, DP_REQ_DROP: frame_q <= cur_q.first;
      DP_INS_AT_I:              ins_q   <= '{first: s_q, last: e_q};
      DP_RSV_TRUNC, DP_RSV_DROP: s_q    <= cur_q.last;
      DP_RSV_SPLIT:             ins_q   <= '{first: e_q, last: cur_q.last};
      DP_RSV_SKIP:              s_q     <= cur_q.first;
      DP_RESP: begin
        out_q.page_frame <= frame_q;
        out_q.status     <= cmd_i.status;
      end
      default: ;
    endcase
  end

  assign stat_o.cnt_zero  = (count_q == '0);
  assign stat_o.cnt_full  = (count_q == cnt_t'(MaxRanges));
  assign stat_o.i_ge_cnt  = (i_q >= count_q);
  assign stat_o.k_gt_p    = (k_q > p_q);
  assign stat_o.k1_lt_cnt = (k_inc < count_q);
  assign stat_o.req_hit   = (next_first == cur_q.last);
  assign stat_o.cs_eq_e   = (cur_q.first == e_q);
  assign stat_o.ce_eq_s   = (cur_q.last == s_q);
  assign stat_o.cs_gt_e   = (cur_q.first > e_q);
  assign stat_o.cs_lt_s   = (cur_q.first < s_q);
  assign stat_o.cs_eq_s   = (cur_q.first == s_q);
  assign stat_o.ce_lt_e   = (cur_q.last < e_q);
  assign stat_o.ce_gt_s   = (cur_q.last > s_q);
  assign stat_o.ce_gt_e   = (cur_q.last > e_q);
  assign stat_o.ce_eq_e   = (cur_q.last == e_q);
  assign stat_o.cs_ge_e   = (cur_q.first >= e_q);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

// ===== rtl/core/fpra_ctrl.sv =====
// Controller state machine: sequences walks, table shifts and the response.
// Depends on fpra_pkg.
`default_nettype none
module fpra_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         in_cmd_i,
  input  wire fpra_pkg::dp_stat_t stat_i,
  output fpra_pkg::dp_cmd_t       cmd_o
);
  import fpra_pkg::*;

  state_e  state_q, state_d;
  cmd_e    kind_q, kind_d;
  status_e status_q, status_d;
  logic    ret_walk_q, ret_walk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      kind_q     <= CMD_NONE;
      status_q   <= ST_OK;
      ret_walk_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      status_q   <= status_d;
      ret_walk_q <= ret_walk_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    status_d   = status_q;
    ret_walk_d = ret_walk_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: DP_NOP, status: status_q};
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          kind_d   = cmd_e'(in_cmd_i);
          status_d = ST_OK;
          unique case (cmd_e'(in_cmd_i))
            CMD_REQUEST: begin
              if (stat_i.cnt_zero) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                state_d = S_WALK;
              end
            end
            CMD_ADD, CMD_RESERVE: state_d = S_WALK;
            default:              state_d = S_RESP;
          endcase
        end
      end
      S_WALK: begin
        if (stat_i.i_ge_cnt) begin
          if (kind_q == CMD_ADD) begin
            cmd_o.op = DP_INS_AT_I;
            state_d  = S_INS_CHK;
          end else begin
            state_d = S_RESP;
          end
        end else begin
          cmd_o.op = DP_READ_I;
          state_d  = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd_o.op = DP_LATCH;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        if (kind_q == CMD_REQUEST) begin
          if (stat_i.req_hit) begin
            cmd_o.op   = DP_REQ_DROP;
            ret_walk_d = 1'b0;
            state_d    = S_DN_CHK;
          end else begin
            cmd_o.op = DP_REQ_WRITE;
            state_d  = S_RESP;
          end
        end else if (kind_q == CMD_ADD) begin
          priority if (stat_i.cs_eq_e) begin
            cmd_o.op = DP_ADD_SETSTART;
            state_d  = S_RESP;
          end else if (stat_i.ce_eq_s) begin
            cmd_o.op = DP_ADD_SETEND;
            state_d  = S_RESP;
          end else if (stat_i.cs_gt_e) begin
            cmd_o.op = DP_INS_AT_I;
            state_d  = S_INS_CHK;
          end else begin
            cmd_o.op = DP_INC_I;
            state_d  = S_WALK;
          end
        end else begin
          priority if (stat_i.cs_lt_s) begin
            priority if (stat_i.ce_lt_e && stat_i.ce_gt_s) begin
              // Entry ends inside the range: cut its tail and go on from its old end.
              cmd_o.op = DP_RSV_TRUNC;
              state_d  = S_WALK;
            end else if (stat_i.ce_gt_e) begin
              if (stat_i.cnt_full) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                cmd_o.op = DP_RSV_SPLIT;
                state_d  = S_INS_CHK;
              end
            end else if (stat_i.ce_eq_e) begin
              cmd_o.op = DP_RSV_CUTEND;
              state_d  = S_RESP;
            end else begin
              cmd_o.op = DP_INC_I;
              state_d  = S_WALK;
            end
          end else if (stat_i.cs_eq_s) begin
            priority if (stat_i.ce_lt_e) begin
              cmd_o.op   = DP_RSV_DROP;
              ret_walk_d = 1'b1;
              state_d    = S_DN_CHK;
            end else if (stat_i.ce_eq_e) begin
              cmd_o.op   = DP_RSV_DROP;
              ret_walk_d = 1'b0;
              state_d    = S_DN_CHK;
            end else begin
              cmd_o.op = DP_RSV_SETSTART;
              state_d  = S_RESP;
            end
          end else begin
            // Gap before the entry: skip to its start; look at it again unless that is at or past the end.
            cmd_o.op = DP_RSV_SKIP;
            state_d  = stat_i.cs_ge_e ? S_RESP : S_EVAL;
          end
        end
      end
      S_INS_CHK: begin
        priority if (stat_i.cnt_full) begin
          status_d = ST_FULL;
          state_d  = S_RESP;
        end else if (stat_i.k_gt_p) begin
          state_d = S_UP_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_UP_RD: begin
        cmd_o.op = DP_UP_RD;
        state_d  = S_UP_WR;
      end
      S_UP_WR: begin
        cmd_o.op = DP_UP_WR;
        state_d  = S_INS_CHK;
      end
      S_INS_WR: begin
        cmd_o.op = DP_INS_WR;
        state_d  = S_RESP;
      end
      S_DN_CHK: begin
        if (stat_i.k1_lt_cnt) begin
          state_d = S_DN_RD;
        end else begin
          cmd_o.op = DP_DROP_DONE;
          state_d  = ret_walk_q ? S_WALK : S_RESP;
        end
      end
      S_DN_RD: begin
        cmd_o.op = DP_DN_RD;
        state_d  = S_DN_WR;
      end
      S_DN_WR: begin
        cmd_o.op = DP_DN_WR;
        state_d  = S_DN_CHK;
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = DP_RESP;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire
